@@ hdl/dll_pkg.sv @@
`timescale 1ns / 1ps

package dll_pkg;

    // Operation codes carried in the request
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_GET        = 3'd4,
        OP_INSERT     = 3'd5,
        OP_ERASE      = 3'd6
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // Request transfer
    typedef struct packed {
        logic [2:0]  operation;
        logic [8:0]  position;
        logic [63:0] payload;
    } req_t;

    // Response transfer
    typedef struct packed {
        status_t     status;
        logic [7:0]  node_slot;
        logic [63:0] node_value;
    } rsp_t;

    // Walker status towards the sequencer
    typedef struct packed {
        logic done;
        logic at_end;
    } walk_stat_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_FRONT,
        ST_FRONT2,
        ST_BACK,
        ST_BACK2,
        ST_WALK,
        ST_INS_CHK,
        ST_INS_W2,
        ST_GET_RD,
        ST_UNLINK_RD,
        ST_UNLINK_W,
        ST_RESP
    } state_t;

endpackage

@@ hdl/doubly_linked_list_manager.sv @@
`timescale 1ns / 1ps
// Push and insert report a full status when the pool is full; pop on an empty list, and get
// or erase at an index past the end of the list, report a miss; insert past the end appends.
// The walk follows one link per cycle; one item at a time, the next request taken
// the cycle after the response is loaded, so a stalled response holds the block busy.
// Reset (rst_n, asynchronous, active low) empties the list; node memories keep stale data.
module doubly_linked_list_manager #(
    parameter int POOL_SLOTS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dll_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dll_pkg::rsp_t rsp
);

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

    dll_pkg::state_t state_reg, state_next;

    logic [2:0]          op_reg, op_next;
    logic [8:0]          pos_reg, pos_next;
    logic [63:0]         payload_reg, payload_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [LW-1:0]       r_reg, r_next;
    logic [LW-1:0]       l_reg, l_next;
    dll_pkg::status_t    st_reg, st_next;
    logic [63:0]         val_reg, val_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       tail_reg, tail_next;
    logic [LW-1:0]       fresh_reg, fresh_next;
    logic [LW-1:0]       ftop_reg, ftop_next;
    logic                rsp_valid_reg, rsp_valid_next;
    dll_pkg::rsp_t       rsp_reg, rsp_next;

    logic                accept;
    logic                rsp_load;
    logic                can_alloc;
    logic [SW-1:0]       alloc_slot;
    logic [LW-1:0]       slot_ext;
    logic [LW-1:0]       ftop_dec;
    logic [LW-1:0]       end_slot;

    logic                val_we,  next_we,  prev_we,  fs_we;
    logic [SW-1:0]       val_addr, next_addr, prev_addr, fs_addr;
    logic [63:0]         val_wdata, val_rdata;
    logic [LW-1:0]       next_wdata, next_rdata;
    logic [LW-1:0]       prev_wdata, prev_rdata;
    logic [SW-1:0]       fs_wdata, fs_rdata;

    logic [LW-1:0]       walk_p;
    dll_pkg::walk_stat_t walk_stat;

    // Handshake
    assign req_ready = (state_reg == dll_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_load  = (state_reg == dll_pkg::ST_RESP) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Slot allocation: free stack first, then never-used slots
    assign ftop_dec   = ftop_reg - LW'(1);
    assign can_alloc  = (ftop_reg != '0) || (fresh_reg < NIL);
    assign alloc_slot = (ftop_reg != '0) ? fs_rdata : fresh_reg[SW-1:0];
    assign slot_ext   = LW'(slot_reg);
    assign end_slot   = (req.operation == dll_pkg::OP_POP_BACK) ? tail_reg : head_reg;

    // Node memories
    dll_ram #(.WIDTH(64), .DEPTH(POOL_SLOTS)) u_val_ram (
        .clk(clk), .we(val_we), .addr(val_addr), .wdata(val_wdata), .rdata(val_rdata)
    );

    dll_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_next_ram (
        .clk(clk), .we(next_we), .addr(next_addr), .wdata(next_wdata), .rdata(next_rdata)
    );

    dll_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_prev_ram (
        .clk(clk), .we(prev_we), .addr(prev_addr), .wdata(prev_wdata), .rdata(prev_rdata)
    );

    dll_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_free_ram (
        .clk(clk), .we(fs_we), .addr(fs_addr), .wdata(fs_wdata), .rdata(fs_rdata)
    );

    // Index walker
    dll_walk #(.POOL_SLOTS(POOL_SLOTS)) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .active     (state_reg == dll_pkg::ST_WALK),
        .pos        (pos_reg),
        .head       (head_reg),
        .link_rdata (next_rdata),
        .p          (walk_p),
        .stat       (walk_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dll_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.operation) inside
                        dll_pkg::OP_PUSH_FRONT, dll_pkg::OP_PUSH_BACK, dll_pkg::OP_INSERT:
                            state_next = dll_pkg::ST_ALLOC;
                        dll_pkg::OP_POP_FRONT, dll_pkg::OP_POP_BACK:
                            state_next = (end_slot == NIL) ? dll_pkg::ST_RESP
                                                           : dll_pkg::ST_UNLINK_RD;
                        dll_pkg::OP_GET, dll_pkg::OP_ERASE:
                            state_next = dll_pkg::ST_WALK;
                        default:
                            state_next = dll_pkg::ST_RESP;
                    endcase
                end
            end
            dll_pkg::ST_ALLOC:
            begin
                if (!can_alloc)
                begin
                    state_next = dll_pkg::ST_RESP;
                end
                else if (op_reg == dll_pkg::OP_PUSH_FRONT)
                begin
                    state_next = dll_pkg::ST_FRONT;
                end
                else if (op_reg == dll_pkg::OP_PUSH_BACK)
                begin
                    state_next = dll_pkg::ST_BACK;
                end
                else
                begin
                    state_next = dll_pkg::ST_WALK;
                end
            end
            dll_pkg::ST_FRONT:     state_next = dll_pkg::ST_FRONT2;
            dll_pkg::ST_FRONT2:    state_next = dll_pkg::ST_RESP;
            dll_pkg::ST_BACK:      state_next = dll_pkg::ST_BACK2;
            dll_pkg::ST_BACK2:     state_next = dll_pkg::ST_RESP;
            dll_pkg::ST_WALK:
            begin
                if (walk_stat.done)
                begin
                    if (op_reg == dll_pkg::OP_INSERT)
                    begin
                        state_next = walk_stat.at_end ? dll_pkg::ST_BACK : dll_pkg::ST_INS_CHK;
                    end
                    else if (walk_stat.at_end)
                    begin
                        state_next = dll_pkg::ST_RESP;
                    end
                    else if (op_reg == dll_pkg::OP_GET)
                    begin
                        state_next = dll_pkg::ST_GET_RD;
                    end
                    else
                    begin
                        state_next = dll_pkg::ST_UNLINK_W;
                    end
                end
            end
            dll_pkg::ST_INS_CHK:
            begin
                state_next = (prev_rdata == NIL) ? dll_pkg::ST_FRONT : dll_pkg::ST_INS_W2;
            end
            dll_pkg::ST_INS_W2:    state_next = dll_pkg::ST_RESP;
            dll_pkg::ST_GET_RD:    state_next = dll_pkg::ST_RESP;
            dll_pkg::ST_UNLINK_RD: state_next = dll_pkg::ST_UNLINK_W;
            dll_pkg::ST_UNLINK_W:  state_next = dll_pkg::ST_RESP;
            dll_pkg::ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = dll_pkg::ST_IDLE;
                end
            end
            default:               state_next = dll_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        payload_next   = payload_reg;
        slot_next      = slot_reg;
        r_next         = r_reg;
        l_next         = l_reg;
        st_next        = st_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fresh_next     = fresh_reg;
        ftop_next      = ftop_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        val_we     = 1'b0;
        val_addr   = slot_reg;
        val_wdata  = payload_reg;
        next_we    = 1'b0;
        next_addr  = slot_reg;
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_addr  = slot_reg;
        prev_wdata = NIL;
        fs_we      = 1'b0;
        fs_addr    = ftop_dec[SW-1:0];
        fs_wdata   = slot_reg;

        unique case (state_reg)
            dll_pkg::ST_IDLE:
            begin
                // Capture the request; the free stack top is read meanwhile
                if (accept)
                begin
                    op_next      = req.operation;
                    pos_next     = req.position;
                    payload_next = req.payload;
                    slot_next    = end_slot[SW-1:0];
                    st_next      = dll_pkg::STATUS_MISS;
                    val_next     = '0;
                end
            end
            dll_pkg::ST_ALLOC:
            begin
                if (!can_alloc)
                begin
                    st_next = dll_pkg::STATUS_FULL;
                end
                else
                begin
                    slot_next = alloc_slot;
                    val_we    = 1'b1;
                    val_addr  = alloc_slot;
                    st_next   = dll_pkg::STATUS_OK;
                    val_next  = payload_reg;
                    if (ftop_reg != '0)
                    begin
                        ftop_next = ftop_dec;
                    end
                    else
                    begin
                        fresh_next = fresh_reg + LW'(1);
                    end
                end
            end
            dll_pkg::ST_FRONT:
            begin
                // Link the new node ahead of the head
                next_we    = 1'b1;
                next_wdata = head_reg;
                prev_we    = 1'b1;
                prev_wdata = NIL;
            end
            dll_pkg::ST_FRONT2:
            begin
                prev_we    = (head_reg != NIL);
                prev_addr  = head_reg[SW-1:0];
                prev_wdata = slot_ext;
                head_next  = slot_ext;
                if (tail_reg == NIL)
                begin
                    tail_next = slot_ext;
                end
            end
            dll_pkg::ST_BACK:
            begin
                // Link the new node behind the tail
                prev_we    = 1'b1;
                prev_wdata = tail_reg;
                next_we    = 1'b1;
                next_wdata = NIL;
            end
            dll_pkg::ST_BACK2:
            begin
                next_we    = (tail_reg != NIL);
                next_addr  = tail_reg[SW-1:0];
                next_wdata = slot_ext;
                tail_next  = slot_ext;
                if (head_reg == NIL)
                begin
                    head_next = slot_ext;
                end
            end
            dll_pkg::ST_WALK:
            begin
                // Follow the walker; links and value of the current node are read
                next_addr = walk_p[SW-1:0];
                prev_addr = walk_p[SW-1:0];
                val_addr  = walk_p[SW-1:0];
                if (walk_stat.done)
                begin
                    r_next = walk_p;
                    if (op_reg != dll_pkg::OP_INSERT && !walk_stat.at_end)
                    begin
                        slot_next = walk_p[SW-1:0];
                    end
                end
            end
            dll_pkg::ST_INS_CHK:
            begin
                if (prev_rdata != NIL)
                begin
                    l_next     = prev_rdata;
                    prev_we    = 1'b1;
                    prev_wdata = prev_rdata;
                    next_we    = 1'b1;
                    next_wdata = r_reg;
                end
            end
            dll_pkg::ST_INS_W2:
            begin
                next_we    = 1'b1;
                next_addr  = l_reg[SW-1:0];
                next_wdata = slot_ext;
                prev_we    = 1'b1;
                prev_addr  = r_reg[SW-1:0];
                prev_wdata = slot_ext;
            end
            dll_pkg::ST_GET_RD:
            begin
                st_next  = dll_pkg::STATUS_OK;
                val_next = val_rdata;
            end
            dll_pkg::ST_UNLINK_RD:
            begin
                // Reads of both links are issued at the default address
            end
            dll_pkg::ST_UNLINK_W:
            begin
                // Bridge the neighbours and push the slot onto the free stack
                next_we    = (prev_rdata != NIL);
                next_addr  = prev_rdata[SW-1:0];
                next_wdata = next_rdata;
                prev_we    = (next_rdata != NIL);
                prev_addr  = next_rdata[SW-1:0];
                prev_wdata = prev_rdata;
                if (prev_rdata == NIL)
                begin
                    head_next = next_rdata;
                end
                if (next_rdata == NIL)
                begin
                    tail_next = prev_rdata;
                end
                if (ftop_reg < NIL)
                begin
                    fs_we     = 1'b1;
                    fs_addr   = ftop_reg[SW-1:0];
                    ftop_next = ftop_reg + LW'(1);
                end
                st_next  = dll_pkg::STATUS_OK;
                val_next = '0;
            end
            dll_pkg::ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase

        // Response register: load when free, drop on transfer
        if (rsp_load)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.status     = st_reg;
            rsp_next.node_slot  = (st_reg == dll_pkg::STATUS_OK) ? 8'(slot_reg) : 8'd0;
            rsp_next.node_value = val_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dll_pkg::ST_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            fresh_reg     <= '0;
            ftop_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fresh_reg     <= fresh_next;
            ftop_reg      <= ftop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        payload_reg <= payload_next;
        slot_reg    <= slot_next;
        r_reg       <= r_next;
        l_reg       <= l_next;
        st_reg      <= st_next;
        val_reg     <= val_next;
        rsp_reg     <= rsp_next;
    end

endmodule

@@ hdl/dll_ram.sv @@
`timescale 1ns / 1ps

module dll_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register the read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hdl/dll_walk.sv @@
`timescale 1ns / 1ps

module dll_walk #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             active,
    input  logic [8:0]                       pos,
    input  logic [$clog2(POOL_SLOTS+1)-1:0]  head,
    input  logic [$clog2(POOL_SLOTS+1)-1:0]  link_rdata,
    output logic [$clog2(POOL_SLOTS+1)-1:0]  p,
    output dll_pkg::walk_stat_t              stat
);

    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

    logic       first_reg;
    logic       first_next;
    logic [8:0] cnt_reg;
    logic [8:0] cnt_next;

    // Current node: head on the first step, then the link just read
    assign p           = first_reg ? head : link_rdata;
    assign stat.at_end = (p == NIL);
    assign stat.done   = stat.at_end || (cnt_reg == pos);

    // Advance one link per cycle until the index or the end is reached
    always_comb
    begin
        first_next = first_reg;
        cnt_next   = cnt_reg;
        if (!active)
        begin
            first_next = 1'b1;
            cnt_next   = '0;
        end
        else if (!stat.done)
        begin
            first_next = 1'b0;
            cnt_next   = cnt_reg + 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hdl/dll_checker.sv @@
`timescale 1ns / 1ps

module dll_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input dll_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input dll_pkg::rsp_t rsp
);

    // A failed operation reports no slot and no value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != dll_pkg::STATUS_OK) |->
            (rsp.node_slot == 8'd0) && (rsp.node_value == 64'd0))
    else $error("failed response carries a slot or value");

    // A stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

    // A waiting request holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("waiting request changed");

    // Every request leaves the idle state when taken, so ready drops after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

    // No response during reset
    assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
    else $error("response valid in reset");

endmodule

bind doubly_linked_list_manager dll_checker u_dll_checker (.*);
